>>> rtl/dqp_pkg.sv
// dqp_pkg: shared types, constants and coefficient tables of the q projector
// used by every module of detector_q_projection except dqp_delay; depends on nothing
`default_nettype none

package dqp_pkg;

  // field and datapath widths
  localparam int ANGLE_W  = 16;
  localparam int ENERGY_W = 24;
  localparam int EFIX_W   = 23;
  localparam int SCALE_W  = 32;
  localparam int ROW_W    = 48;
  localparam int COEF_W   = 16;
  localparam int PROJ_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int Q30_W    = 30;
  localparam int TRIG_W   = 32;
  localparam int ROOT_W   = 28;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;

  // angle units: 1/128 degree
  localparam logic [15:0] UNITS_TURN    = 16'd46080;
  localparam logic [15:0] UNITS_THREEQ  = 16'd34560;
  localparam logic [15:0] UNITS_HALF    = 16'd23040;
  localparam logic [15:0] UNITS_QUARTER = 16'd11520;
  localparam logic [15:0] UNITS_EIGHTH  = 16'd5760;
  localparam logic [31:0] RAD_PER_UNIT  = 32'd585635;

  // series lengths
  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;

  // pipeline latencies in cycles
  localparam int KIN_LAT  = 2 + ROOT_W;
  localparam int SC_LAT   = 4 + 3 * COS_STEPS;
  localparam int PROJ_LAT = 5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIXED_ENERGY = 3'd0,
    REG_INV_SCALE    = 3'd1,
    REG_ROW_X        = 3'd2,
    REG_ROW_Y        = 3'd3,
    REG_ROW_Z        = 3'd4
  } cfg_reg_t;

  // kinematic configuration handed to the wavevector unit
  typedef struct packed {
    logic [EFIX_W-1:0]  efix;
    logic [SCALE_W-1:0] scale;
  } kin_cfg_t;

  // unit direction, Q30
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } dir_t;

  // series divisor of horner step idx
  function automatic logic [7:0] hdiv(input logic is_cos, input int idx);
    logic [7:0] d;
    d = 8'd2;
    if (is_cos) begin
      case (idx)
        0: d = 8'd132;
        1: d = 8'd90;
        2: d = 8'd56;
        3: d = 8'd30;
        4: d = 8'd12;
        default: d = 8'd2;
      endcase
    end else begin
      case (idx)
        0: d = 8'd110;
        1: d = 8'd72;
        2: d = 8'd42;
        3: d = 8'd20;
        default: d = 8'd6;
      endcase
    end
    return d;
  endfunction

  // floor(2^30 / divisor) for the reciprocal multiply
  function automatic logic [Q30_W-1:0] hrecip(input logic is_cos, input int idx);
    logic [Q30_W-1:0] m;
    m = 30'd536870912;
    if (is_cos) begin
      case (idx)
        0: m = 30'd8134407;
        1: m = 30'd11930464;
        2: m = 30'd19173961;
        3: m = 30'd35791394;
        4: m = 30'd89478485;
        default: m = 30'd536870912;
      endcase
    end else begin
      case (idx)
        0: m = 30'd9761289;
        1: m = 30'd14913080;
        2: m = 30'd25565281;
        3: m = 30'd53687091;
        default: m = 30'd178956970;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dqp_delay.sv
// dqp_delay: fixed-length register line that aligns side data with the pipeline
// depends on nothing
`default_nettype none

module dqp_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);

  logic [W-1:0] line_r [DEPTH];

  // shift one place each cycle
  always_ff @(posedge clk) begin
    line_r[0] <= din;
    for (int i = 1; i < DEPTH; i++) begin
      line_r[i] <= line_r[i-1];
    end
  end

  assign dout = line_r[DEPTH-1];

endmodule

`default_nettype wire

>>> rtl/dqp_isqrt.sv
// dqp_isqrt: pipelined integer square root, one result bit per stage
// depends on dqp_pkg
`default_nettype none

module dqp_isqrt
  import dqp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [RAD_W-1:0]  rad,
  output logic      [ROOT_W-1:0] root
);

  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W-1];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign rad_in  = rad_r[g-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[g] <= {root_in[ROOT_W-2:0], ge};
    end

    if (g < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        rad_r[g] <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/dqp_kin.sv
// dqp_kin: incident and final wavevector, floor(sqrt(energy * scale)), pipelined
// depends on dqp_pkg and dqp_isqrt, dqp_delay
`default_nettype none

module dqp_kin
  import dqp_pkg::*;
(
  input  wire logic                       clk,
  input  wire kin_cfg_t                   cfg,
  input  wire logic signed [ENERGY_W-1:0] energy,
  output logic             [ROOT_W-1:0]   ki,
  output logic             [ROOT_W-1:0]   kf,
  output logic                            invalid
);

  logic signed [ENERGY_W+1:0] diff;
  logic [ENERGY_W-1:0] diff_r;
  logic                inv_r;
  logic [EFIX_W-1:0]   efix_r;
  logic [RAD_W-1:0]    ki_sq_r;
  logic [RAD_W-1:0]    kf_sq_r;

  // energy difference; negative means the final energy is not reachable
  assign diff = $signed({3'b000, cfg.efix}) - (ENERGY_W+2)'(energy);

  always_ff @(posedge clk) begin
    inv_r  <= diff[ENERGY_W+1];
    diff_r <= diff[ENERGY_W+1] ? '0 : diff[ENERGY_W-1:0];
    efix_r <= cfg.efix;
  end

  // squared wavevectors
  always_ff @(posedge clk) begin
    ki_sq_r <= RAD_W'(efix_r) * RAD_W'(cfg.scale);
    kf_sq_r <= RAD_W'(diff_r) * RAD_W'(cfg.scale);
  end

  dqp_isqrt u_sqrt_ki (.clk(clk), .rad(ki_sq_r), .root(ki));
  dqp_isqrt u_sqrt_kf (.clk(clk), .rad(kf_sq_r), .root(kf));

  dqp_delay #(.W(1), .DEPTH(KIN_LAT - 1)) u_inv_dly (
    .clk(clk), .din(inv_r), .dout(invalid)
  );

endmodule

`default_nettype wire

>>> rtl/dqp_horner.sv
// dqp_horner: truncated taylor series by horner steps in q30, three stages a step
// depends on dqp_pkg
`default_nettype none

module dqp_horner
  import dqp_pkg::*;
#(
  parameter int   N_STEPS = SIN_STEPS,
  parameter logic IS_COS  = 1'b0
) (
  input  wire logic             clk,
  input  wire logic [Q30_W-1:0] x2,
  output logic      [Q30_W:0]   t
);

  localparam logic [Q30_W:0] ONE = (Q30_W+1)'(1) << Q30_W;

  logic [Q30_W:0]   t_r   [N_STEPS];
  logic [Q30_W-1:0] x2h_r [N_STEPS-1];

  for (genvar g = 0; g < N_STEPS; g++) begin : g_step
    localparam logic [7:0]       DV = hdiv(IS_COS, g);
    localparam logic [Q30_W-1:0] RC = hrecip(IS_COS, g);

    logic [Q30_W:0]     t_in;
    logic [Q30_W-1:0]   x_in;
    logic [2*Q30_W:0]   prod;
    logic [2*Q30_W-1:0] recm;
    logic [Q30_W+7:0]   qd;
    logic [Q30_W-1:0]   rem;
    logic [Q30_W-1:0]   va_r, xa_r;
    logic [Q30_W-1:0]   qb_r, vb_r, xb_r;
    logic [Q30_W-1:0]   q;

    if (g == 0) begin : g_first
      assign t_in = ONE;
      assign x_in = x2;
    end else begin : g_next
      assign t_in = t_r[g-1];
      assign x_in = x2h_r[g-1];
    end

    // x^2 * t in q30
    assign prod = (2*Q30_W+1)'(x_in) * (2*Q30_W+1)'(t_in);
    always_ff @(posedge clk) begin
      va_r <= prod[2*Q30_W-1:Q30_W];
      xa_r <= x_in;
    end

    // quotient estimate by reciprocal, low by at most one
    assign recm = (2*Q30_W)'(va_r) * (2*Q30_W)'(RC);
    always_ff @(posedge clk) begin
      qb_r <= recm[2*Q30_W-1:Q30_W];
      vb_r <= va_r;
      xb_r <= xa_r;
    end

    // correct the estimate, then one minus quotient
    assign qd  = (Q30_W+8)'(qb_r) * (Q30_W+8)'(DV);
    assign rem = vb_r - qd[Q30_W-1:0];
    assign q   = qb_r + Q30_W'(rem >= Q30_W'(DV));
    always_ff @(posedge clk) begin
      t_r[g] <= ONE - (Q30_W+1)'(q);
    end

    if (g < N_STEPS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        x2h_r[g] <= xb_r;
      end
    end
  end

  assign t = t_r[N_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/dqp_sincos.sv
// dqp_sincos: sine and cosine of an angle in 1/128 degree, q30, pipelined
// depends on dqp_pkg, dqp_horner and dqp_delay
`default_nettype none

module dqp_sincos
  import dqp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [ANGLE_W-1:0] angle,
  output logic signed      [TRIG_W-1:0]  sin_q,
  output logic signed      [TRIG_W-1:0]  cos_q
);

  logic signed [ANGLE_W+1:0] a_s;
  logic [ANGLE_W-1:0] a;
  logic [1:0]         quad;
  logic [ANGLE_W-1:0] base;
  logic [ANGLE_W-1:0] r;
  logic [12:0]        x_r;
  logic [1:0]         quad_r;
  logic               swap_r;
  logic [31:0]        xrad;
  logic [Q30_W-1:0]   x30_r;
  logic [2*Q30_W-1:0] xsq;
  logic [Q30_W-1:0]   x2_r;
  logic [Q30_W-1:0]   x30_d;
  logic [Q30_W:0]     hs;
  logic [Q30_W:0]     hc;
  logic [2*Q30_W:0]   sprod;
  logic [Q30_W-1:0]   sn_r;
  logic [Q30_W-1:0]   sn_d;
  logic [2:0]         qs_d;
  logic signed [TRIG_W-1:0] sb;
  logic signed [TRIG_W-1:0] cb;

  // fold to one turn, quadrant and an angle of at most one eighth turn
  assign a_s = (ANGLE_W+2)'(angle) + (angle[ANGLE_W-1] ? (ANGLE_W+2)'(UNITS_TURN)
                                                         : (ANGLE_W+2)'(0));
  assign a   = a_s[ANGLE_W-1:0];
  always_comb begin
    if (a >= UNITS_THREEQ) begin
      quad = 2'd3;
      base = UNITS_THREEQ;
    end else if (a >= UNITS_HALF) begin
      quad = 2'd2;
      base = UNITS_HALF;
    end else if (a >= UNITS_QUARTER) begin
      quad = 2'd1;
      base = UNITS_QUARTER;
    end else begin
      quad = 2'd0;
      base = '0;
    end
  end
  assign r = a - base;

  always_ff @(posedge clk) begin
    x_r    <= (r > UNITS_EIGHTH) ? 13'(UNITS_QUARTER - r) : r[12:0];
    swap_r <= (r > UNITS_EIGHTH);
    quad_r <= quad;
  end

  // radians in q30
  assign xrad = 32'(x_r) * RAD_PER_UNIT + 32'd2;
  always_ff @(posedge clk) begin
    x30_r <= xrad[31:2];
  end

  // x squared in q30
  assign xsq = (2*Q30_W)'(x30_r) * (2*Q30_W)'(x30_r);
  always_ff @(posedge clk) begin
    x2_r <= xsq[2*Q30_W-1:Q30_W];
  end

  dqp_horner #(.N_STEPS(SIN_STEPS), .IS_COS(1'b0)) u_sin_series (
    .clk(clk), .x2(x2_r), .t(hs)
  );
  dqp_horner #(.N_STEPS(COS_STEPS), .IS_COS(1'b1)) u_cos_series (
    .clk(clk), .x2(x2_r), .t(hc)
  );

  dqp_delay #(.W(Q30_W), .DEPTH(1 + 3 * SIN_STEPS)) u_x30_dly (
    .clk(clk), .din(x30_r), .dout(x30_d)
  );

  // sine is x times the series
  assign sprod = (2*Q30_W+1)'(x30_d) * (2*Q30_W+1)'(hs);
  always_ff @(posedge clk) begin
    sn_r <= sprod[2*Q30_W-1:Q30_W];
  end

  dqp_delay #(.W(Q30_W), .DEPTH(3 * (COS_STEPS - SIN_STEPS) - 1)) u_sn_dly (
    .clk(clk), .din(sn_r), .dout(sn_d)
  );
  dqp_delay #(.W(3), .DEPTH(2 + 3 * COS_STEPS)) u_quad_dly (
    .clk(clk), .din({swap_r, quad_r}), .dout(qs_d)
  );

  // undo the eighth-turn fold, then place in the quadrant
  assign sb = qs_d[2] ? TRIG_W'(hc) : TRIG_W'(sn_d);
  assign cb = qs_d[2] ? TRIG_W'(sn_d) : TRIG_W'(hc);

  always_ff @(posedge clk) begin
    unique case (qs_d[1:0])
      2'd0: begin
        sin_q <= sb;
        cos_q <= cb;
      end
      2'd1: begin
        sin_q <= cb;
        cos_q <= -sb;
      end
      2'd2: begin
        sin_q <= -sb;
        cos_q <= -cb;
      end
      default: begin
        sin_q <= -cb;
        cos_q <= sb;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dqp_project.sv
// dqp_project: q = ki*x - kf*dir, then rotation by the matrix with saturation
// depends on dqp_pkg
`default_nettype none

module dqp_project
  import dqp_pkg::*;
(
  input  wire logic              clk,
  input  wire dir_t              dir,
  input  wire logic [ROOT_W-1:0] ki,
  input  wire logic [ROOT_W-1:0] kf,
  input  wire logic [ROW_W-1:0]  row_x,
  input  wire logic [ROW_W-1:0]  row_y,
  input  wire logic [ROW_W-1:0]  row_z,
  output logic signed [PROJ_W-1:0] u1,
  output logic signed [PROJ_W-1:0] u2,
  output logic signed [PROJ_W-1:0] u3
);

  localparam int PK_W  = TRIG_W + ROOT_W + 1;
  localparam int PS_W  = PK_W - Q30_W;
  localparam int MP_W  = COEF_W + 32;
  localparam int SUM_W = MP_W + 2;

  logic signed [ROOT_W:0]   kfs;
  logic signed [PK_W-1:0]   pkx, pky, pkz;
  logic signed [PS_W-1:0]   px_r, py_r, pz_r;
  logic [ROOT_W-1:0]        ki_r;
  logic signed [31:0]       q_r [3];
  logic [ROW_W-1:0]         rows [3];
  logic signed [MP_W-1:0]   mp_r [3][3];
  logic signed [SUM_W-1:0]  sum_r [3];
  logic signed [PROJ_W-1:0] u_r [3];

  // kf times each direction component, floor shift
  assign kfs = $signed({1'b0, kf});
  assign pkx = PK_W'(dir.x) * PK_W'(kfs);
  assign pky = PK_W'(dir.y) * PK_W'(kfs);
  assign pkz = PK_W'(dir.z) * PK_W'(kfs);
  always_ff @(posedge clk) begin
    px_r <= pkx[PK_W-1:Q30_W];
    py_r <= pky[PK_W-1:Q30_W];
    pz_r <= pkz[PK_W-1:Q30_W];
    ki_r <= ki;
  end

  // momentum transfer
  always_ff @(posedge clk) begin
    q_r[0] <= $signed(32'(ki_r)) - 32'(px_r);
    q_r[1] <= -(32'(py_r));
    q_r[2] <= -(32'(pz_r));
  end

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;

  // coefficient products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mp_r[i][j] <= MP_W'($signed(rows[i][COEF_W*j +: COEF_W])) * MP_W'(q_r[j]);
      end
    end
  end

  // row sums
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sum_r[i] <= SUM_W'(mp_r[i][0]) + SUM_W'(mp_r[i][1]) + SUM_W'(mp_r[i][2]);
    end
  end

  // q2.14 scale down and clamp to 32 bits
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if ((sum_r[i][SUM_W-1:PROJ_W+13] == '0) ||
          (sum_r[i][SUM_W-1:PROJ_W+13] == '1)) begin
        u_r[i] <= sum_r[i][PROJ_W+13:14];
      end else if (sum_r[i][SUM_W-1]) begin
        u_r[i] <= {1'b1, {(PROJ_W-1){1'b0}}};
      end else begin
        u_r[i] <= {1'b0, {(PROJ_W-1){1'b1}}};
      end
    end
  end

  assign u1 = u_r[0];
  assign u2 = u_r[1];
  assign u3 = u_r[2];

endmodule

`default_nettype wire

>>> rtl/detector_q_projection.sv
// detector_q_projection: top level of the detector momentum projector
// depends on dqp_pkg, dqp_kin, dqp_sincos, dqp_project and dqp_delay
//
// channel   ports                                    handshake
// input     in_polar_angle, in_azimuth_angle,        start high, busy low
//           in_energy_transfer
// result    out_proj_u1..3, out_energy_out,          out_valid, one cycle
//           out_kinematic_invalid
// config    cfg_we, cfg_index, cfg_data              cfg_we high
//
// one item enters every cycle; busy stays low, the pipeline never holds
// each result passes the input register, the wavevector unit (a difference
// stage, a multiply stage and a 28-stage root pipeline) and the projection
// stages; the angle path runs alongside and is padded to match
// synchronous active-low reset clears the valid line and the configuration registers
// the receiver cannot stall; a result is shown for exactly one cycle
`default_nettype none

module detector_q_projection
  import dqp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [ANGLE_W-1:0]   in_polar_angle,
  input  wire logic signed [ANGLE_W-1:0]   in_azimuth_angle,
  input  wire logic signed [ENERGY_W-1:0]  in_energy_transfer,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [ROW_W-1:0]            cfg_data,
  output logic                             out_valid,
  output logic signed [PROJ_W-1:0]         out_proj_u1,
  output logic signed [PROJ_W-1:0]         out_proj_u2,
  output logic signed [PROJ_W-1:0]         out_proj_u3,
  output logic signed [ENERGY_W-1:0]       out_energy_out,
  output logic                             out_kinematic_invalid
);

  localparam int LINE_LEN  = KIN_LAT + PROJ_LAT;
  localparam int TOTAL_LAT = LINE_LEN + 1;
  localparam int DIR_PAD   = KIN_LAT - SC_LAT - 1;

  logic [EFIX_W-1:0]  efix_r;
  logic [SCALE_W-1:0] scale_r;
  logic [ROW_W-1:0]   row_x_r, row_y_r, row_z_r;
  kin_cfg_t           kcfg;

  logic                       v0_r;
  logic [LINE_LEN-1:0]        vline_r;
  logic signed [ANGLE_W-1:0]  pol_r, azi_r;
  logic signed [ENERGY_W-1:0] en_r;

  logic [ROOT_W-1:0]        ki, kf;
  logic                     kin_inv;
  logic signed [TRIG_W-1:0] sp, cp, ss, cs;
  logic signed [2*TRIG_W-1:0] eyp, ezp;
  dir_t                     dir_r;
  dir_t                     dir_d;
  logic [ENERGY_W-1:0]      en_d;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      efix_r  <= '0;
      scale_r <= '0;
      row_x_r <= '0;
      row_y_r <= '0;
      row_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIXED_ENERGY: efix_r  <= cfg_data[EFIX_W-1:0];
        REG_INV_SCALE:    scale_r <= cfg_data[SCALE_W-1:0];
        REG_ROW_X:        row_x_r <= cfg_data;
        REG_ROW_Y:        row_y_r <= cfg_data;
        REG_ROW_Z:        row_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign kcfg.efix  = efix_r;
  assign kcfg.scale = scale_r;

  // input register and valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      vline_r <= '0;
    end else begin
      v0_r    <= start && !busy;
      vline_r <= {vline_r[LINE_LEN-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    pol_r <= in_polar_angle;
    azi_r <= in_azimuth_angle;
    en_r  <= in_energy_transfer;
  end

  dqp_kin u_kin (
    .clk(clk), .cfg(kcfg), .energy(en_r), .ki(ki), .kf(kf), .invalid(kin_inv)
  );

  dqp_sincos u_polar (.clk(clk), .angle(pol_r), .sin_q(sp), .cos_q(cp));
  dqp_sincos u_azim  (.clk(clk), .angle(azi_r), .sin_q(ss), .cos_q(cs));

  // unit direction from the two angles
  assign eyp = sp * cs;
  assign ezp = sp * ss;
  always_ff @(posedge clk) begin
    dir_r.x <= cp;
    dir_r.y <= eyp[Q30_W+TRIG_W-1:Q30_W];
    dir_r.z <= ezp[Q30_W+TRIG_W-1:Q30_W];
  end

  dqp_delay #(.W($bits(dir_t)), .DEPTH(DIR_PAD)) u_dir_dly (
    .clk(clk), .din(dir_r), .dout(dir_d)
  );

  dqp_project u_proj (
    .clk(clk), .dir(dir_d), .ki(ki), .kf(kf),
    .row_x(row_x_r), .row_y(row_y_r), .row_z(row_z_r),
    .u1(out_proj_u1), .u2(out_proj_u2), .u3(out_proj_u3)
  );

  dqp_delay #(.W(ENERGY_W), .DEPTH(LINE_LEN)) u_en_dly (
    .clk(clk), .din(en_r), .dout(en_d)
  );
  dqp_delay #(.W(1), .DEPTH(PROJ_LAT)) u_inv_dly (
    .clk(clk), .din(kin_inv), .dout(out_kinematic_invalid)
  );

  assign out_energy_out = $signed(en_d);
  assign out_valid      = vline_r[LINE_LEN-1];

  // every accepted item comes out after the fixed latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##TOTAL_LAT out_valid)
    else $error("accepted item did not come out");

  // no result without an item accepted earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, TOTAL_LAT))
    else $error("result without an accepted item");

  // an unreachable final energy gives a zero final wavevector
  a_kf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vline_r[KIN_LAT-1] && kin_inv |-> kf == '0)
    else $error("kf not zero on invalid item");

endmodule

`default_nettype wire
